// ===== hdl/dbt_pkg.sv =====
package dbt_pkg;

  // sine/cosine core works in Q30
  localparam int QFRAC = 30;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // reciprocal multiply for the series divisors: a < 2^33 keeps the error below one
  localparam int RECIP_SHIFT = 34;

  // Q30 to Q16 rounding
  localparam int Q16_SHIFT = 14;
  localparam logic [30:0] Q16_HALF = 31'd8192;

  // product back to sample scale
  localparam int PROD_SHIFT = 16;
  localparam int PROD_HALF = 32768;

  // cosine and sine sit in Q2.16
  localparam int TRIG_BITS = 18;

  typedef logic [1:0] quad_t;
  localparam quad_t QUAD_0 = 2'd0;
  localparam quad_t QUAD_1 = 2'd1;
  localparam quad_t QUAD_2 = 2'd2;

endpackage

// ===== hdl/dbt_div_pipe.sv =====
// restoring divider, one quotient bit per stage
module dbt_div_pipe #(
  parameter int VW = 21,
  parameter int QW = 40,
  parameter int TW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [VW-1:0] in_rem,
  input  logic [QW-1:0] in_low,
  input  logic [VW-1:0] in_div,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [VW-1:0] out_rem,
  output logic [TW-1:0] out_tag
);

  logic          vld [0:QW];
  logic [VW-1:0] rem [0:QW];
  logic [QW-1:0] low [0:QW];
  logic [QW-1:0] quo [0:QW];
  logic [VW-1:0] dvs [0:QW];
  logic [TW-1:0] tag [0:QW];

  assign vld[0] = in_valid;
  assign rem[0] = in_rem;
  assign low[0] = in_low;
  assign quo[0] = '0;
  assign dvs[0] = in_div;
  assign tag[0] = in_tag;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [VW:0] trial;
    logic [VW:0] diff;
    logic        ge;

    assign trial = {rem[s], low[s][QW-1]};
    assign ge    = trial >= {1'b0, dvs[s]};
    assign diff  = trial - {1'b0, dvs[s]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      rem[s+1] <= ge ? diff[VW-1:0] : trial[VW-1:0];
      low[s+1] <= low[s] << 1;
      quo[s+1] <= {quo[s][QW-2:0], ge};
      dvs[s+1] <= dvs[s];
      tag[s+1] <= tag[s];
    end
  end

  assign out_valid = vld[QW];
  assign out_quo   = quo[QW];
  assign out_rem   = rem[QW];
  assign out_tag   = tag[QW];

endmodule

// ===== hdl/dbt_sincos.sv =====
// phase to Q2.16 cosine and sine: Taylor series, three stages per term
module dbt_sincos import dbt_pkg::*; #(
  parameter int PHASE_BITS = 16,
  parameter int TW = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [PHASE_BITS-1:0]       in_phase,
  input  logic [TW-1:0]               in_tag,
  output logic                        out_valid,
  output logic signed [TRIG_BITS-1:0] out_cos,
  output logic signed [TRIG_BITS-1:0] out_sin,
  output logic [TW-1:0]               out_tag
);

  localparam int FW = PHASE_BITS - 2;
  localparam int TERMS = 6;
  localparam logic signed [34:0] ONE_S = 35'(Q30_ONE);

  // angle in Q30
  logic [FW+30:0] xp;
  logic           vx;
  logic [30:0]    x_r;
  quad_t          quad_x;
  logic [TW-1:0]  tag_x;
  logic [61:0]    xx;

  assign xp = (FW+31)'(in_phase[FW-1:0]) * (FW+31)'(HALF_PI_Q30);
  assign xx = 62'(x_r) * 62'(x_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      vx <= 1'b0;
    end else begin
      vx <= in_valid;
    end
    x_r    <= 31'(xp >> FW);
    quad_x <= in_phase[PHASE_BITS-1:PHASE_BITS-2];
    tag_x  <= in_tag;
  end

  logic               vld  [0:TERMS];
  logic [32:0]        tc   [0:TERMS];
  logic [32:0]        ts   [0:TERMS];
  logic signed [34:0] cs   [0:TERMS];
  logic signed [34:0] sn   [0:TERMS];
  logic [31:0]        x2   [0:TERMS];
  quad_t              quad [0:TERMS];
  logic [TW-1:0]      tag  [0:TERMS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= vx;
    end
    x2[0]   <= 32'(xx >> QFRAC);
    tc[0]   <= 33'(Q30_ONE);
    ts[0]   <= 33'(x_r);
    cs[0]   <= ONE_S;
    sn[0]   <= $signed(35'(x_r));
    quad[0] <= quad_x;
    tag[0]  <= tag_x;
  end

  for (genvar gi = 1; gi <= TERMS; gi++) begin : g_term
    localparam int DC = (2*gi - 1) * (2*gi);
    localparam int DS = (2*gi) * (2*gi + 1);
    localparam logic [33:0] MC = 34'((64'd1 << RECIP_SHIFT) / DC);
    localparam logic [33:0] MS = 34'((64'd1 << RECIP_SHIFT) / DS);

    logic               va, vb;
    logic [32:0]        a_cos, a_sin, b_acos, b_asin, q_cos, q_sin;
    logic signed [34:0] c_a, s_a, c_b, s_b;
    logic [31:0]        x2_a, x2_b;
    quad_t              quad_a, quad_b;
    logic [TW-1:0]      tag_a, tag_b;
    logic [39:0]        r_cos, r_sin;
    logic [32:0]        t_cos, t_sin;

    // term times x^2
    always_ff @(posedge clk) begin
      if (rst) begin
        va <= 1'b0;
      end else begin
        va <= vld[gi-1];
      end
      a_cos  <= 33'((65'(tc[gi-1]) * 65'(x2[gi-1])) >> QFRAC);
      a_sin  <= 33'((65'(ts[gi-1]) * 65'(x2[gi-1])) >> QFRAC);
      c_a    <= cs[gi-1];
      s_a    <= sn[gi-1];
      x2_a   <= x2[gi-1];
      quad_a <= quad[gi-1];
      tag_a  <= tag[gi-1];
    end

    // estimate of the quotient, low by at most one
    always_ff @(posedge clk) begin
      if (rst) begin
        vb <= 1'b0;
      end else begin
        vb <= va;
      end
      q_cos  <= 33'((67'(a_cos) * 67'(MC)) >> RECIP_SHIFT);
      q_sin  <= 33'((67'(a_sin) * 67'(MS)) >> RECIP_SHIFT);
      b_acos <= a_cos;
      b_asin <= a_sin;
      c_b    <= c_a;
      s_b    <= s_a;
      x2_b   <= x2_a;
      quad_b <= quad_a;
      tag_b  <= tag_a;
    end

    assign r_cos = 40'(b_acos) - 40'(q_cos) * 40'(DC);
    assign r_sin = 40'(b_asin) - 40'(q_sin) * 40'(DS);
    assign t_cos = (r_cos >= 40'(DC)) ? q_cos + 33'd1 : q_cos;
    assign t_sin = (r_sin >= 40'(DS)) ? q_sin + 33'd1 : q_sin;

    // correct and accumulate
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[gi] <= 1'b0;
      end else begin
        vld[gi] <= vb;
      end
      tc[gi] <= t_cos;
      ts[gi] <= t_sin;
      if (gi % 2 == 1) begin
        cs[gi] <= c_b - $signed({2'b00, t_cos});
      end else begin
        cs[gi] <= c_b + $signed({2'b00, t_cos});
      end
      if (gi > TERMS - 1) begin
        sn[gi] <= s_b;
      end else if (gi % 2 == 1) begin
        sn[gi] <= s_b - $signed({2'b00, t_sin});
      end else begin
        sn[gi] <= s_b + $signed({2'b00, t_sin});
      end
      x2[gi]   <= x2_b;
      quad[gi] <= quad_b;
      tag[gi]  <= tag_b;
    end
  end

  // clamp to [0, 1.0] and round to Q16
  logic [30:0]   c_cl, s_cl;
  logic          vr;
  logic [16:0]   c_r, s_r;
  quad_t         quad_r;
  logic [TW-1:0] tag_r;

  always_comb begin
    if (cs[TERMS] < 0) begin
      c_cl = '0;
    end else if (cs[TERMS] > ONE_S) begin
      c_cl = Q30_ONE;
    end else begin
      c_cl = cs[TERMS][30:0];
    end
    if (sn[TERMS] < 0) begin
      s_cl = '0;
    end else if (sn[TERMS] > ONE_S) begin
      s_cl = Q30_ONE;
    end else begin
      s_cl = sn[TERMS][30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= 1'b0;
    end else begin
      vr <= vld[TERMS];
    end
    c_r    <= 17'((32'(c_cl) + 32'(Q16_HALF)) >> Q16_SHIFT);
    s_r    <= 17'((32'(s_cl) + 32'(Q16_HALF)) >> Q16_SHIFT);
    quad_r <= quad[TERMS];
    tag_r  <= tag[TERMS];
  end

  logic signed [TRIG_BITS-1:0] c_p, s_p;
  assign c_p = $signed({1'b0, c_r});
  assign s_p = $signed({1'b0, s_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vr;
    end
    case (quad_r)
      QUAD_0: begin
        out_cos <= c_p;
        out_sin <= s_p;
      end
      QUAD_1: begin
        out_cos <= -s_p;
        out_sin <= c_p;
      end
      QUAD_2: begin
        out_cos <= -c_p;
        out_sin <= -s_p;
      end
      default: begin
        out_cos <= s_p;
        out_sin <= -c_p;
      end
    endcase
    out_tag <= tag_r;
  end

endmodule

// ===== hdl/dft_bin_term.sv =====
// One sample's contribution to one DFT bin: the phase (bin*step mod N)/N of a turn is
// quantized to PHASE_BITS bits, and real_part/imag_part are sample*cos and sample*sin
// (Q2.16 trig, rounded half up, saturated). busy stays low: a new item can start every
// cycle. Each result comes out on done for one cycle, in input order, after the bin*step
// register, the bit-per-stage modulo divider, the scaling register, the phase divider, the
// three-stage-per-term sine/cosine series and the product and saturation registers. The
// receiver cannot stall the block, so done must be taken when it shows. Write total_steps
// only while no item is in flight; a value of 0 acts as 1.
module dft_bin_term import dbt_pkg::*; #(
  parameter int SAMPLE_BITS = 24,
  parameter int INDEX_BITS  = 20,
  parameter int PHASE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] sample_value,
  input  logic [INDEX_BITS-1:0]         step_index,
  input  logic [INDEX_BITS-1:0]         bin_index,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [INDEX_BITS:0]           cfg_data,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] real_part,
  output logic signed [SAMPLE_BITS-1:0] imag_part,
  output logic [INDEX_BITS-1:0]         bin_echo,
  output logic                          step_beyond_total
);

  localparam int SB = SAMPLE_BITS;
  localparam int IB = INDEX_BITS;
  localparam int PB = PHASE_BITS;
  localparam int TAGW = SB + IB + 1;
  localparam int PW = SB + TRIG_BITS;
  localparam logic signed [SB+2:0] SAT_HI = (SB+3)'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [SB+2:0] SAT_LO = -SAT_HI - (SB+3)'(1);

  logic [IB:0] total_steps;
  logic [IB:0] period;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign period    = (total_steps == '0) ? (IB+1)'(1) : total_steps;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_steps <= (IB+1)'(1024);
    end else if (cfg_valid && cfg_ready) begin
      total_steps <= cfg_data;
    end
  end

  // bin times step
  logic              v0;
  logic [2*IB-1:0]   kn;
  logic [TAGW-1:0]   tag0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    kn   <= (2*IB)'(bin_index) * (2*IB)'(step_index);
    tag0 <= {sample_value, bin_index, ({1'b0, step_index} > period)};
  end

  logic            vm;
  logic [2*IB-1:0] quo_m;
  logic [IB:0]     rem_m;
  logic [TAGW-1:0] tag_m;

  dbt_div_pipe #(.VW(IB + 1), .QW(2*IB), .TW(TAGW)) u_mod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v0),
    .in_rem    ('0),
    .in_low    (kn),
    .in_div    (period),
    .in_tag    (tag0),
    .out_valid (vm),
    .out_quo   (quo_m),
    .out_rem   (rem_m),
    .out_tag   (tag_m)
  );

  // scaled remainder plus half period, ready for the phase divide
  logic              vd;
  logic [IB+PB+1:0]  dvd;
  logic [TAGW-1:0]   tag_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else begin
      vd <= vm;
    end
    dvd   <= (IB+PB+2)'({rem_m, {PB{1'b0}}}) + (IB+PB+2)'(period >> 1);
    tag_d <= tag_m;
  end

  logic            vp;
  logic [PB:0]     quo_p;
  logic [IB:0]     rem_p;
  logic [TAGW-1:0] tag_p;

  dbt_div_pipe #(.VW(IB + 1), .QW(PB + 1), .TW(TAGW)) u_phase (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vd),
    .in_rem    (dvd[IB+PB+1:PB+1]),
    .in_low    (dvd[PB:0]),
    .in_div    (period),
    .in_tag    (tag_d),
    .out_valid (vp),
    .out_quo   (quo_p),
    .out_rem   (rem_p),
    .out_tag   (tag_p)
  );

  logic                        vt;
  logic signed [TRIG_BITS-1:0] cos_q, sin_q;
  logic [TAGW-1:0]             tag_t;

  dbt_sincos #(.PHASE_BITS(PB), .TW(TAGW)) u_sincos (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vp),
    .in_phase  (quo_p[PB-1:0]),
    .in_tag    (tag_p),
    .out_valid (vt),
    .out_cos   (cos_q),
    .out_sin   (sin_q),
    .out_tag   (tag_t)
  );

  // products
  logic                 vx;
  logic signed [PW-1:0] p_re, p_im;
  logic signed [SB-1:0] smp;
  logic [IB-1:0]        k_x;
  logic                 f_x;

  assign smp = $signed(tag_t[TAGW-1:IB+1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vx <= 1'b0;
    end else begin
      vx <= vt;
    end
    p_re <= smp * cos_q;
    p_im <= smp * sin_q;
    k_x  <= tag_t[IB:1];
    f_x  <= tag_t[0];
  end

  // round half up, saturate
  logic signed [PW:0]   rs_re, rs_im;
  logic signed [SB+2:0] sh_re, sh_im;

  assign rs_re = (PW+1)'(p_re) + (PW+1)'(PROD_HALF);
  assign rs_im = (PW+1)'(p_im) + (PW+1)'(PROD_HALF);
  assign sh_re = rs_re[PW:PROD_SHIFT];
  assign sh_im = rs_im[PW:PROD_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vx;
    end
    if (sh_re > SAT_HI) begin
      real_part <= SAT_HI[SB-1:0];
    end else if (sh_re < SAT_LO) begin
      real_part <= SAT_LO[SB-1:0];
    end else begin
      real_part <= sh_re[SB-1:0];
    end
    if (sh_im > SAT_HI) begin
      imag_part <= SAT_HI[SB-1:0];
    end else if (sh_im < SAT_LO) begin
      imag_part <= SAT_LO[SB-1:0];
    end else begin
      imag_part <= sh_im[SB-1:0];
    end
    bin_echo          <= k_x;
    step_beyond_total <= f_x;
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int SW = 24;
  localparam int IW = 20;
  localparam int PW = 16;
  localparam int LATENCY = 2 * IW + PW + 27;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic signed [SW-1:0] re;
    logic signed [SW-1:0] im;
    logic [IW-1:0]        bin;
    logic                 beyond;
  } term_t;

  typedef struct packed {
    logic signed [SW-1:0] v;
    logic [IW-1:0]        n;
    logic [IW-1:0]        k;
    logic                 known;
    term_t                res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [SW-1:0] sample_value = '0;
  logic [IW-1:0] step_index = '0;
  logic [IW-1:0] bin_index = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IW:0] cfg_data = '0;
  logic done;
  logic signed [SW-1:0] real_part;
  logic signed [SW-1:0] imag_part;
  logic [IW-1:0] bin_echo;
  logic step_beyond_total;

  dft_bin_term dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .sample_value(sample_value), .step_index(step_index), .bin_index(bin_index),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .real_part(real_part), .imag_part(imag_part),
    .bin_echo(bin_echo), .step_beyond_total(step_beyond_total)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [IW:0] period_reg = 21'd1024;
  term_t pending_terms[$];
  int errors = 0;
  int items_sent = 0;
  int terms_seen = 0;
  int periods_used = 0;
  int cycles = 0;

  // cos and sin in Q2.16 of a PW-bit phase, series evaluated in Q30
  function automatic void trig_q16(input logic [PW-1:0] ph, output longint cs,
                                   output longint sn);
    logic [63:0] x, x2, ts, tc, f;
    longint c, s, cq, sq;
    f = 64'(ph[PW-3:0]);
    x = (f * 64'd1686629713) >> (PW - 2);
    x2 = (x * x) >> 30;
    s = longint'(x);
    c = longint'(64'd1 << 30);
    ts = x;
    tc = 64'd1 << 30;
    for (int i = 1; i <= 6; i++) begin
      tc = ((tc * x2) >> 30) / 64'((2 * i - 1) * (2 * i));
      if (i % 2 == 1) c -= longint'(tc); else c += longint'(tc);
      if (i <= 5) begin
        ts = ((ts * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
        if (i % 2 == 1) s -= longint'(ts); else s += longint'(ts);
      end
    end
    if (c < 0) c = 0;
    if (c > (longint'(1) << 30)) c = longint'(1) << 30;
    if (s < 0) s = 0;
    if (s > (longint'(1) << 30)) s = longint'(1) << 30;
    cq = (c + 8192) >>> 14;
    sq = (s + 8192) >>> 14;
    case (ph[PW-1:PW-2])
      2'd0: begin cs = cq;  sn = sq;  end
      2'd1: begin cs = -sq; sn = cq;  end
      2'd2: begin cs = -cq; sn = -sq; end
      default: begin cs = sq; sn = -cq; end
    endcase
  endfunction

  function automatic logic signed [SW-1:0] round_sat(input longint v, input longint w);
    longint q;
    q = (v * w + 32768) >>> 16;
    if (q > 8388607) q = 8388607;
    if (q < -8388608) q = -8388608;
    return q[SW-1:0];
  endfunction

  function automatic term_t bin_term(input logic signed [SW-1:0] v, input logic [IW-1:0] n,
                                     input logic [IW-1:0] k);
    term_t t;
    logic [63:0] per, r, ph;
    longint cs, sn;
    per = (period_reg == 0) ? 64'd1 : 64'(period_reg);
    r = (64'(k) * 64'(n)) % per;
    ph = ((r << PW) + per / 2) / per;
    trig_q16(ph[PW-1:0], cs, sn);
    t.re = round_sat(longint'(v), cs);
    t.im = round_sat(longint'(v), sn);
    t.bin = k;
    t.beyond = (64'(n) > per);
    return t;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_terms.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    term_t want;
    if (!rst && done) begin
      terms_seen++;
      if (pending_terms.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat at cycle %0d", cycles);
      end else begin
        want = pending_terms.pop_front();
        if (want.re !== real_part || want.im !== imag_part || want.bin !== bin_echo ||
            want.beyond !== step_beyond_total) begin
          errors++;
          if (errors <= 10) begin
            $write("mismatch: exp re=%0d im=%0d bin=%0d flag=%0b",
                   want.re, want.im, want.bin, want.beyond);
            $display(" got re=%0d im=%0d bin=%0d flag=%0b",
                     real_part, imag_part, bin_echo, step_beyond_total);
          end
        end
      end
    end
  end

  task automatic send_sample(input logic signed [SW-1:0] v, input logic [IW-1:0] n,
                             input logic [IW-1:0] k, input int gap, input bit known,
                             input term_t res);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    sample_value <= v;
    step_index <= n;
    bin_index <= k;
    do @(posedge clk); while (busy);
    pending_terms.push_back(known ? res : bin_term(v, n, k));
    items_sent++;
  endtask

  // let everything drain, then write the period while nothing is in flight
  task automatic set_period(input logic [IW:0] val);
    start <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    period_reg = val;
    periods_used++;
  endtask

  function automatic term_t mk(input int re, input int im, input int k, input bit fl);
    term_t t;
    t.re = SW'(re);
    t.im = SW'(im);
    t.bin = IW'(k);
    t.beyond = fl;
    return t;
  endfunction

  function automatic logic signed [SW-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 24'sh800000;
      1: return 24'sh7fffff;
      2: return SW'(int'($urandom_range(0, 255)) - 128);
      default: return SW'($urandom);
    endcase
  endfunction

  row_t plan[] = '{
    '{24'sd0,        20'd0,       20'd0,       1'b1, mk(0, 0, 0, 0)},
    '{24'sh7fffff,   20'd5,       20'd0,       1'b1, mk(8388607, 0, 0, 0)},
    '{24'sh800000,   20'd7,       20'd0,       1'b1, mk(-8388608, 0, 0, 0)},
    '{24'sh800000,   20'd1,       20'd512,     1'b1, mk(8388607, 0, 512, 0)},
    '{24'sh7fffff,   20'd1,       20'd512,     1'b1, mk(-8388607, 0, 512, 0)},
    '{24'sd1000,     20'd1,       20'd256,     1'b1, mk(0, 1000, 256, 0)},
    '{24'sd1000,     20'd1,       20'd768,     1'b1, mk(0, -1000, 768, 0)},
    '{24'sd100,      20'd1024,    20'd0,       1'b1, mk(100, 0, 0, 0)},
    '{24'sd100,      20'd1025,    20'd0,       1'b1, mk(100, 0, 0, 1)},
    '{24'sd5,        20'hfffff,   20'd0,       1'b1, mk(5, 0, 0, 1)},
    '{24'sd0,        20'hfffff,   20'hfffff,   1'b1, mk(0, 0, 20'hfffff, 1)},
    '{24'sh7fffff,   20'd3,       20'd41,      1'b0, '0},
    '{24'sh800000,   20'hfffff,   20'hfffff,   1'b0, '0},
    '{24'sh555555,   20'haaaaa,   20'h55555,   1'b0, '0},
    '{24'shaaaaaa,   20'h55555,   20'haaaaa,   1'b0, '0},
    '{-24'sd1,       20'd1,       20'd1,       1'b0, '0},
    '{24'sd1,        20'd1,       20'd128,     1'b0, '0}
  };

  initial begin
    logic [IW:0] per_list[] = '{21'd0, 21'd1, 21'd1048576, 21'h1fffff, 21'd7, 21'd360};
    int gap_cap;
    logic [IW-1:0] n, k;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i])
      send_sample(plan[i].v, plan[i].n, plan[i].k, $urandom_range(0, 2), plan[i].known,
                  plan[i].res);

    // a zero period acts as one: phase zero, flag set for steps above one
    set_period(21'd0);
    send_sample(24'sd77, 20'd1, 20'd9, 0, 1'b1, mk(77, 0, 9, 0));
    send_sample(24'sd77, 20'd2, 20'd9, 0, 1'b1, mk(77, 0, 9, 1));

    for (int ph = 0; ph < 10; ph++) begin
      if (ph < per_list.size()) set_period(per_list[ph]);
      else set_period(21'($urandom_range(1, 1048576)));
      gap_cap = (ph % 3 == 0) ? 0 : 18;
      for (int i = 0; i < 172; i++) begin
        // steps mostly around the period so the flag goes both ways
        if ($urandom_range(0, 3) == 0) n = IW'($urandom);
        else n = IW'($urandom_range(0, period_reg + 2));
        k = ($urandom_range(0, 3) == 0) ? IW'($urandom) : IW'($urandom_range(0, 4096));
        send_sample(rand_sample(), n, k, $urandom_range(0, gap_cap), 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (pending_terms.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("%0d samples sent, %0d terms checked over %0d period settings, %0d errors",
             items_sent, terms_seen, periods_used + 1, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
